/* design/atinv_pkg.sv */
// Shared widths, codes and types for the affine transform inverse block.
`timescale 1ns / 1ps
package atinv_pkg;

  localparam int EW = 32;
  localparam int NROW = 3;
  localparam int NCOL = 4;
  localparam int NENT = 4;
  localparam int IN_W = NROW * NCOL * EW;
  localparam int OUT_W = NENT * EW;
  localparam int USER_W = 4;
  localparam int PW = 2 * EW;
  localparam int XW = PW + 1;
  localparam int HW = XW - EW;
  localparam int PPW = HW + EW;
  localparam int DTW = 100;
  localparam int NW = 128;
  localparam int QW = EW + 1;
  localparam int CW = NW + 6;
  localparam int DIV_STAGES = QW + 1;

  localparam logic [1:0] ROW_0 = 2'd0;
  localparam logic [1:0] ROW_1 = 2'd1;
  localparam logic [1:0] ROW_LAST = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SING = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic [NROW-1:0][EW-1:0] vec_t;
  typedef logic [NCOL-1:0][NROW-1:0][EW-1:0] mat_t;

  typedef struct packed {
    logic [1:0] row;
    mat_t       col;
  } job_t;

  typedef struct packed {
    logic [1:0]                  row;
    logic                        sing;
    logic [NENT-1:0]             neg;
    logic [NENT-1:0][NW-1:0]     num;
    logic [DTW-1:0]              den;
  } dvs_t;

endpackage

/* design/atinv_seq.sv */
// Input holding register and row issue sequencer.
`timescale 1ns / 1ps
module atinv_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv_i,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [atinv_pkg::IN_W-1:0]   in_tdata,
  output atinv_pkg::job_t              job_o,
  output logic                         job_vld_o
);

  atinv_pkg::mat_t mat_r;
  atinv_pkg::mat_t mat_in;
  logic            full_r;
  logic            full_nxt;
  logic [1:0]      row_r;
  logic [1:0]      row_nxt;
  logic            issue;
  logic            issue_last;
  logic            accept;

  always_comb begin
    for (int k = 0; k < atinv_pkg::NCOL; k++) begin
      for (int i = 0; i < atinv_pkg::NROW; i++) begin
        mat_in[k][i] = in_tdata[(atinv_pkg::NCOL * i + k) * atinv_pkg::EW +: atinv_pkg::EW];
      end
    end
  end

  assign issue      = full_r && adv_i;
  assign issue_last = issue && (row_r == atinv_pkg::ROW_LAST);
  assign in_tready  = !full_r || issue_last;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    full_nxt = full_r;
    row_nxt  = row_r;
    if (accept) begin
      full_nxt = 1'b1;
      row_nxt  = atinv_pkg::ROW_0;
    end else if (issue_last) begin
      full_nxt = 1'b0;
      row_nxt  = atinv_pkg::ROW_0;
    end else if (issue) begin
      row_nxt = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      row_r  <= atinv_pkg::ROW_0;
    end else begin
      full_r <= full_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mat_r <= mat_in;
    end
  end

  assign job_o.row = row_r;
  assign job_o.col = mat_r;
  assign job_vld_o = full_r;

endmodule

/* design/atinv_arith.sv */
// Cross products, dot products and divider operand setup, five stages.
`timescale 1ns / 1ps
module atinv_arith #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv_i,
  input  atinv_pkg::job_t job_i,
  input  logic            job_vld_i,
  output atinv_pkg::dvs_t dvs_o,
  output logic            dvs_vld_o
);

  localparam int EW = atinv_pkg::EW;
  localparam int PW = atinv_pkg::PW;
  localparam int XW = atinv_pkg::XW;
  localparam int HW = atinv_pkg::HW;
  localparam int PPW = atinv_pkg::PPW;
  localparam int DTW = atinv_pkg::DTW;
  localparam int NW = atinv_pkg::NW;

  typedef logic [5:0][PW-1:0] prods_t;
  typedef logic [2:0][XW-1:0] xvec_t;
  typedef logic [2:0][PPW-1:0] pvec_t;

  function automatic logic signed [PW-1:0] smul(logic signed [EW-1:0] x,
                                                logic signed [EW-1:0] y);
    return x * y;
  endfunction

  function automatic logic signed [PPW-1:0] pmul(logic signed [HW-1:0] x,
                                                 logic signed [EW-1:0] y);
    return x * y;
  endfunction

  function automatic prods_t xprod(atinv_pkg::vec_t u, atinv_pkg::vec_t v);
    prods_t p;
    p[0] = smul(u[1], v[2]);
    p[1] = smul(u[2], v[1]);
    p[2] = smul(u[2], v[0]);
    p[3] = smul(u[0], v[2]);
    p[4] = smul(u[0], v[1]);
    p[5] = smul(u[1], v[0]);
    return p;
  endfunction

  function automatic xvec_t xdiff(prods_t p);
    xvec_t r;
    for (int j = 0; j < 3; j++) begin
      r[j] = $signed({p[2*j][PW-1], p[2*j]}) - $signed({p[2*j+1][PW-1], p[2*j+1]});
    end
    return r;
  endfunction

  function automatic logic signed [DTW-1:0] dsum(pvec_t hi, pvec_t lo);
    logic signed [DTW-1:0] acc;
    acc = '0;
    for (int j = 0; j < 3; j++) begin
      acc = acc + (DTW'($signed(hi[j])) <<< EW) + DTW'($signed(lo[j]));
    end
    return acc;
  endfunction

  logic [4:0] vld_r;

  // stage 1
  atinv_pkg::vec_t u, v, p_sel;
  prods_t          pk_r, p2_r, pc_r;
  atinv_pkg::vec_t c1_r, p1_r;
  logic [1:0]      row1_r;

  always_comb begin
    case (job_i.row)
      atinv_pkg::ROW_0: begin
        u     = job_i.col[1];
        v     = job_i.col[2];
        p_sel = job_i.col[1];
      end
      atinv_pkg::ROW_1: begin
        u     = job_i.col[2];
        v     = job_i.col[0];
        p_sel = job_i.col[0];
      end
      default: begin
        u     = job_i.col[0];
        v     = job_i.col[1];
        p_sel = job_i.col[3];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      pk_r   <= xprod(u, v);
      p2_r   <= xprod(job_i.col[0], job_i.col[1]);
      pc_r   <= xprod(job_i.col[2], job_i.col[3]);
      c1_r   <= job_i.col[2];
      p1_r   <= p_sel;
      row1_r <= job_i.row;
    end
  end

  // stage 2
  xvec_t           nk2_r, n22_r, q2_r;
  atinv_pkg::vec_t c2_r, p2v_r;
  logic [1:0]      row2_r;

  always_ff @(posedge clk) begin
    if (adv_i) begin
      nk2_r  <= xdiff(pk_r);
      n22_r  <= xdiff(p2_r);
      q2_r   <= (row1_r == atinv_pkg::ROW_LAST) ? xdiff(p2_r) : xdiff(pc_r);
      c2_r   <= c1_r;
      p2v_r  <= p1_r;
      row2_r <= row1_r;
    end
  end

  // stage 3
  pvec_t      dh_r, dl_r, th_r, tl_r;
  xvec_t      nk3_r;
  logic [1:0] row3_r;

  always_ff @(posedge clk) begin
    if (adv_i) begin
      for (int j = 0; j < 3; j++) begin
        dl_r[j] <= pmul({1'b0, n22_r[j][EW-1:0]}, c2_r[j]);
        dh_r[j] <= pmul(n22_r[j][XW-1:EW], c2_r[j]);
        tl_r[j] <= pmul({1'b0, q2_r[j][EW-1:0]}, p2v_r[j]);
        th_r[j] <= pmul(q2_r[j][XW-1:EW], p2v_r[j]);
      end
      nk3_r  <= nk2_r;
      row3_r <= row2_r;
    end
  end

  // stage 4
  logic [DTW-1:0] det4_r, trip4_r;
  xvec_t          nk4_r;
  logic [1:0]     row4_r;

  always_ff @(posedge clk) begin
    if (adv_i) begin
      det4_r  <= dsum(dh_r, dl_r);
      trip4_r <= dsum(th_r, tl_r);
      nk4_r   <= nk3_r;
      row4_r  <= row3_r;
    end
  end

  // stage 5
  atinv_pkg::dvs_t dvs_nxt, dvs_r;
  logic            dneg;
  logic            tpos;
  logic [XW-1:0]   nmag;
  logic [DTW-1:0]  tmag;

  always_comb begin
    dneg         = det4_r[DTW-1];
    dvs_nxt.row  = row4_r;
    dvs_nxt.sing = (det4_r == '0);
    dvs_nxt.den  = dneg ? (~det4_r + 1'b1) : det4_r;
    nmag         = '0;
    for (int j = 0; j < 3; j++) begin
      nmag            = nk4_r[j][XW-1] ? (~nk4_r[j] + 1'b1) : nk4_r[j];
      dvs_nxt.num[j]  = NW'(nmag) << (2 * FRAC_BITS);
      dvs_nxt.neg[j]  = nk4_r[j][XW-1] ^ dneg;
    end
    tpos           = !trip4_r[DTW-1] && (trip4_r != '0);
    tmag           = trip4_r[DTW-1] ? (~trip4_r + 1'b1) : trip4_r;
    dvs_nxt.num[3] = NW'(tmag) << FRAC_BITS;
    dvs_nxt.neg[3] = tpos ^ dneg;
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      dvs_r <= dvs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv_i) begin
      vld_r <= {vld_r[3:0], job_vld_i};
    end
  end

  assign dvs_o     = dvs_r;
  assign dvs_vld_o = vld_r[4];

endmodule

/* design/atinv_div.sv */
// Pipelined restoring divider, one quotient bit per stage with overflow check.
`timescale 1ns / 1ps
module atinv_div (
  input  logic                       clk,
  input  logic                       adv_i,
  input  logic [atinv_pkg::NW-1:0]   num_i,
  input  logic [atinv_pkg::DTW-1:0]  den_i,
  input  logic                       neg_i,
  output logic [atinv_pkg::QW-1:0]   q_o,
  output logic                       ovf_o,
  output logic                       rem_nz_o,
  output logic                       neg_o
);

  localparam int NS = atinv_pkg::DIV_STAGES;
  localparam int NW = atinv_pkg::NW;
  localparam int DTW = atinv_pkg::DTW;
  localparam int QW = atinv_pkg::QW;
  localparam int CW = atinv_pkg::CW;

  logic [NW-1:0]  rem_r [NS];
  logic [DTW-1:0] den_r [NS];
  logic [QW-1:0]  q_r   [NS];
  logic           ovf_r [NS];
  logic           neg_r [NS];

  always_ff @(posedge clk) begin
    if (adv_i) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      q_r[0]   <= '0;
      ovf_r[0] <= (CW'(num_i) >= (CW'(den_i) << QW));
      neg_r[0] <= neg_i;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam int SH = NS - 1 - s;
    logic [CW-1:0] dsh;
    logic          ge;

    assign dsh = CW'(den_r[s-1]) << SH;
    assign ge  = CW'(rem_r[s-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (adv_i) begin
        rem_r[s] <= ge ? NW'(CW'(rem_r[s-1]) - dsh) : rem_r[s-1];
        q_r[s]   <= ge ? (q_r[s-1] | (QW'(1) << SH)) : q_r[s-1];
        den_r[s] <= den_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  assign q_o      = q_r[NS-1];
  assign ovf_o    = ovf_r[NS-1];
  assign rem_nz_o = |rem_r[NS-1];
  assign neg_o    = neg_r[NS-1];

endmodule

/* design/affine_transform_inverse_top.sv */
// Top level of the 3x4 affine transform inverse, Q.FRAC_BITS fixed point.
`timescale 1ns / 1ps
// One matrix in, three inverse rows out (rows 0, 1, 2, tlast on row 2).
// Rows are issued one per cycle while the output is not stalled, from an input
// holding register into a shared arithmetic pipeline, and the next matrix is
// accepted in the cycle the current one issues its last row.
// From input transaction to the first row, data passes the input holding
// register, 5 stages of cross and dot products, 34 stages of bit-serial
// division (overflow check plus 33 quotient bits), and the output register.
// Every entry of a non-singular row is an exact floor division saturated to
// 32 bits; a stalled output freezes the whole pipeline.
module affine_transform_inverse_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // r0c0, r0c1, r0c2, r0c3, r1c0, ..., r2c3, 32 bits each, lowest first
  input  logic [atinv_pkg::IN_W-1:0]     in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_c0, out_c1, out_c2, out_c3, 32 bits each, lowest first
  output logic [atinv_pkg::OUT_W-1:0]    out_tdata,
  // row_index [1:0], status [3:2]
  output logic [atinv_pkg::USER_W-1:0]   out_tuser,
  output logic                           out_tlast
);

  localparam int NS = atinv_pkg::DIV_STAGES;
  localparam int NENT = atinv_pkg::NENT;
  localparam int EW = atinv_pkg::EW;
  localparam int QW = atinv_pkg::QW;

  typedef struct packed {
    logic [1:0] row;
    logic       sing;
  } meta_t;

  logic            adv;
  atinv_pkg::job_t job;
  logic            job_vld;
  atinv_pkg::dvs_t dvs;
  logic            dvs_vld;

  logic [NENT-1:0][QW-1:0] dq;
  logic [NENT-1:0]         dovf, drnz, dneg;

  logic [NS-1:0] mv_r;
  meta_t         meta_r [NS];

  logic                         out_tvalid_r;
  logic [atinv_pkg::OUT_W-1:0]  out_tdata_r, tdata_nxt;
  logic [atinv_pkg::USER_W-1:0] out_tuser_r, tuser_nxt;
  logic                         out_tlast_r;

  assign adv = !out_tvalid_r || out_tready;

  atinv_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_i     (adv),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_o     (job),
    .job_vld_o (job_vld)
  );

  atinv_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_i     (adv),
    .job_i     (job),
    .job_vld_i (job_vld),
    .dvs_o     (dvs),
    .dvs_vld_o (dvs_vld)
  );

  for (genvar e = 0; e < NENT; e++) begin : g_div
    atinv_div u_div (
      .clk      (clk),
      .adv_i    (adv),
      .num_i    (dvs.num[e]),
      .den_i    (dvs.den),
      .neg_i    (dvs.neg[e]),
      .q_o      (dq[e]),
      .ovf_o    (dovf[e]),
      .rem_nz_o (drnz[e]),
      .neg_o    (dneg[e])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= '0;
    end else if (adv) begin
      mv_r <= {mv_r[NS-2:0], dvs_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= '{row: dvs.row, sing: dvs.sing};
      for (int s = 1; s < NS; s++) begin
        meta_r[s] <= meta_r[s-1];
      end
    end
  end

  always_comb begin
    logic [QW:0]   qq;
    logic          sat;
    logic          sat_any;
    logic [EW-1:0] val;
    sat_any   = 1'b0;
    tdata_nxt = '0;
    for (int e = 0; e < NENT; e++) begin
      if (dneg[e]) begin
        qq  = {1'b0, dq[e]} + (QW + 1)'(drnz[e]);
        sat = dovf[e] || (qq > (QW + 1)'(atinv_pkg::SAT_NEG));
        val = sat ? atinv_pkg::SAT_NEG : EW'(-qq);
      end else begin
        qq  = {1'b0, dq[e]};
        sat = dovf[e] || (qq > (QW + 1)'(atinv_pkg::SAT_POS));
        val = sat ? atinv_pkg::SAT_POS : dq[e][EW-1:0];
      end
      sat_any = sat_any || sat;
      tdata_nxt[e*EW +: EW] = meta_r[NS-1].sing ? '0 : val;
    end
    tuser_nxt[1:0] = meta_r[NS-1].row;
    if (meta_r[NS-1].sing) begin
      tuser_nxt[3:2] = atinv_pkg::ST_SING;
    end else if (sat_any) begin
      tuser_nxt[3:2] = atinv_pkg::ST_SAT;
    end else begin
      tuser_nxt[3:2] = atinv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= mv_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= tdata_nxt;
      out_tuser_r <= tuser_nxt;
      out_tlast_r <= (meta_r[NS-1].row == atinv_pkg::ROW_LAST);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3:2] == atinv_pkg::ST_SING) |-> (out_tdata == '0))
    else $error("singular row carries nonzero entries");

  a_sat_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3:2] == atinv_pkg::ST_SAT) |->
      (out_tdata[31:0] == atinv_pkg::SAT_POS) || (out_tdata[31:0] == atinv_pkg::SAT_NEG) ||
      (out_tdata[63:32] == atinv_pkg::SAT_POS) || (out_tdata[63:32] == atinv_pkg::SAT_NEG) ||
      (out_tdata[95:64] == atinv_pkg::SAT_POS) || (out_tdata[95:64] == atinv_pkg::SAT_NEG) ||
      (out_tdata[127:96] == atinv_pkg::SAT_POS) || (out_tdata[127:96] == atinv_pkg::SAT_NEG))
    else $error("saturated status without a saturated entry");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(mv_r))
    else $error("pipeline moved during a stall");

  a_one_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second matrix taken before rows were issued");

endmodule

/* bench/affine_transform_inverse_top_test.sv */
// Self-checking bench for the affine transform inverse block, with a row scoreboard.
`timescale 1ns / 1ps
module affine_transform_inverse_top_test;

  localparam int FB = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef logic signed [129:0] wide_t;
  typedef wide_t vec3_t [3];

  typedef struct {
    logic [1:0]      row;
    logic [3:0][31:0] ent;
    logic            last;
    logic [1:0]      status;
  } inv_row_t;

  class inverse_scoreboard;
    inv_row_t rows_due[$];
    int matrices_seen, rows_checked, sing_rows, sat_rows, errors;

    function vec3_t cross3(vec3_t x, vec3_t y);
      vec3_t r;
      for (int i = 0; i < 3; i++)
        r[i] = x[(i+1)%3] * y[(i+2)%3] - x[(i+2)%3] * y[(i+1)%3];
      return r;
    endfunction

    function wide_t dot3(vec3_t x, vec3_t y);
      return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    function logic [31:0] floor_sat(wide_t n, wide_t d, inout bit sat);
      wide_t q, r;
      q = n / d;
      r = n % d;
      if (r != 0 && ((n < 0) != (d < 0))) q = q - 1;
      if (q > 130'sd2147483647) begin
        sat = 1;
        return atinv_pkg::SAT_POS;
      end
      if (q < -130'sd2147483648) begin
        sat = 1;
        return atinv_pkg::SAT_NEG;
      end
      return q[31:0];
    endfunction

    function void note_matrix(logic [atinv_pkg::IN_W-1:0] d);
      vec3_t col [4];
      vec3_t nrm [3];
      vec3_t cd;
      wide_t det;
      wide_t trip [3];
      inv_row_t e;
      bit sat;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 4; k++)
          col[k][i] = $signed(d[(i*4+k)*32 +: 32]);
      nrm[0] = cross3(col[1], col[2]);
      nrm[1] = cross3(col[2], col[0]);
      nrm[2] = cross3(col[0], col[1]);
      cd = cross3(col[2], col[3]);
      det = dot3(nrm[2], col[2]);
      trip[0] = dot3(col[1], cd);
      trip[1] = dot3(col[0], cd);
      trip[2] = dot3(col[3], nrm[2]);
      matrices_seen++;
      for (int k = 0; k < 3; k++) begin
        sat = 0;
        e.row = k[1:0];
        e.last = (k == 2);
        e.ent = '0;
        if (det == 0) begin
          e.status = atinv_pkg::ST_SING;
        end else begin
          for (int j = 0; j < 3; j++)
            e.ent[j] = floor_sat(nrm[k][j] <<< (2 * FB), det, sat);
          e.ent[3] = floor_sat((-trip[k]) <<< FB, det, sat);
          e.status = sat ? atinv_pkg::ST_SAT : atinv_pkg::ST_OK;
        end
        rows_due.push_back(e);
      end
    endfunction

    function void check_row(logic [atinv_pkg::OUT_W-1:0] data,
                            logic [atinv_pkg::USER_W-1:0] user, logic last);
      inv_row_t e;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row, data %h user %h last %b", $time, data, user, last);
        errors++;
        return;
      end
      e = rows_due.pop_front();
      rows_checked++;
      if (e.status == atinv_pkg::ST_SING) sing_rows++;
      if (e.status == atinv_pkg::ST_SAT) sat_rows++;
      if (user[1:0] !== e.row) begin
        $display("%0t: row_index expected %0d actual %0d", $time, e.row, user[1:0]);
        errors++;
      end
      if (user[3:2] !== e.status) begin
        $display("%0t: status row %0d expected %0d actual %0d", $time, e.row, e.status,
                 user[3:2]);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: tlast row %0d expected %b actual %b", $time, e.row, e.last, last);
        errors++;
      end
      for (int j = 0; j < 4; j++)
        if (data[j*32 +: 32] !== e.ent[j]) begin
          $display("%0t: row %0d c%0d expected %h actual %h", $time, e.row, j, e.ent[j],
                   data[j*32 +: 32]);
          errors++;
        end
    endfunction

    function int pending();
      return rows_due.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [atinv_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [atinv_pkg::OUT_W-1:0] out_tdata;
  logic [atinv_pkg::USER_W-1:0] out_tuser;
  logic out_tlast;

  inverse_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_now = 0;
  int quiet_cycles = 0;

  affine_transform_inverse_top #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_matrix(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_row(out_tdata, out_tuser, out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_now) begin
        out_tready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_now = 0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_matrix(logic [atinv_pkg::IN_W-1:0] m);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= m;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] small_val();
    return $urandom_range(0, 1 << 19) - (1 << 18);
  endfunction

  function automatic logic [atinv_pkg::IN_W-1:0] rand_matrix();
    logic [atinv_pkg::IN_W-1:0] m;
    int pick;
    int src;
    pick = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 4; k++) begin
        if (pick < 40) begin
          if (k == 3) m[(i*4+k)*32 +: 32] = $urandom;
          else if (i == k)
            m[(i*4+k)*32 +: 32] = ($urandom_range(0, 1) ? -1 : 1) *
                                  ($urandom_range(1 << 14, 4 << 16));
          else m[(i*4+k)*32 +: 32] = $urandom_range(0, 1 << 15) - (1 << 14);
        end else if (pick < 60) begin
          m[(i*4+k)*32 +: 32] = small_val();
        end else if (pick < 75) begin
          m[(i*4+k)*32 +: 32] = $signed($urandom) >>> $urandom_range(0, 31);
        end else if (pick < 90) begin
          m[(i*4+k)*32 +: 32] = $urandom;
        end else begin
          m[(i*4+k)*32 +: 32] = small_val();
        end
      end
    if (pick >= 90) begin
      src = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++)
        m[(i*4 + (src+1)%3)*32 +: 32] = m[(i*4+src)*32 +: 32];
    end
    return m;
  endfunction

  function automatic logic [atinv_pkg::IN_W-1:0] diag_matrix(logic [31:0] dv,
                                                             logic [31:0] tv,
                                                             logic [31:0] ov);
    logic [atinv_pkg::IN_W-1:0] m;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 4; k++)
        m[(i*4+k)*32 +: 32] = (k == 3) ? tv : ((i == k) ? dv : ov);
    return m;
  endfunction

  initial begin
    logic [atinv_pkg::IN_W-1:0] m;
    int per_phase [4] = '{20, 45, 45, 40};
    int idle_set [4] = '{0, 63, 0, 24};
    int stall_set [4] = '{0, 0, 63, 24};
    repeat (5) @(negedge clk);
    rst_n <= 1;

    send_matrix(diag_matrix(32'h0001_0000, 32'h0, 32'h0));
    send_matrix('0);
    send_matrix(diag_matrix(32'h0001_0000, 32'h7FFF_FFFF, 32'h0));
    send_matrix(diag_matrix(32'h0001_0000, 32'h8000_0000, 32'h0));
    send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h0));
    send_matrix(diag_matrix(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    send_matrix(diag_matrix(32'h0000_0001, 32'h0001_0000, 32'h0));
    send_matrix(diag_matrix(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    send_matrix(diag_matrix(32'h0002_0000, 32'hFFFE_8000, 32'h0000_4000));
    send_matrix(diag_matrix(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555));
    send_matrix(diag_matrix(32'h0001_0000, 32'h1234_5678, 32'h0001_0000));
    m = diag_matrix(32'h0003_0000, 32'h0, 32'h0);
    m[4*32 +: 4*32] = m[0 +: 4*32];
    send_matrix(m);
    send_matrix(diag_matrix(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0));

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      recv_stall_pct = stall_set[p];
      if (p == 2) begin
        @(negedge clk);
        in_tvalid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        hold_now = 1;
      end
      for (int n = 0; n < per_phase[p]; n++) send_matrix(rand_matrix());
    end
    @(negedge clk);
    in_tvalid <= 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("run: %0d matrices, %0d rows checked (%0d singular, %0d saturated)",
             sb.matrices_seen, sb.rows_checked, sb.sing_rows, sb.sat_rows);
    $display("run: idle and stall phases plus one long output hold-off exercised");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
design/atinv_pkg.sv
design/atinv_seq.sv
design/atinv_arith.sv
design/atinv_div.sv
design/affine_transform_inverse_top.sv
bench/affine_transform_inverse_top_test.sv
